// ===== src/aclrt_pkg.sv =====
// Shared types and constants of the fully associative tag controller.
// Depends on nothing; the top level uses it through scoped names.
package aclrt_pkg;

  localparam int BW_W       = 9;   // block_words register width
  localparam int LINES_W    = 5;   // lines_in_use register width
  localparam int POLICY_W   = 2;
  localparam int SEED_W     = 16;
  localparam int POS_OUT_W  = 5;   // width of the position result field
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_WORDS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINES_IN_USE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_SEED  = 2'd3;

  // Replacement policy codes; any other code means no fill.
  localparam logic [POLICY_W-1:0] POL_LRU    = 2'd0;
  localparam logic [POLICY_W-1:0] POL_RANDOM = 2'd1;

  localparam logic [SEED_W-1:0] LFSR_TAPS = 16'hB400;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DIV    = 6'b000010,
    S_SEARCH = 6'b000100,
    S_RMOD   = 6'b001000,
    S_SHIFT  = 6'b010000,
    S_PLACE  = 6'b100000
  } state_t;

endpackage

// ===== src/aclrt_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Stand-alone; used by the tag controller for the line number and the random pick.
module aclrt_div #(
  parameter int DW = 16,
  parameter int VW = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient,
  output logic [VW-1:0] remainder
);

  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0] cnt;
  logic [DW-1:0] quot;
  logic [VW-1:0] rem;
  logic [VW-1:0] dvs;
  logic [VW:0]   shifted;
  logic [VW:0]   diff;
  logic          ge;

  assign shifted = {rem, quot[DW-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign ge      = (shifted >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CW'(DW);
      end else if (cnt != '0) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (cnt != '0) begin
      quot <= {quot[DW-2:0], ge};
      rem  <= ge ? diff[VW-1:0] : shifted[VW-1:0];
    end
  end

  assign quotient  = quot;
  assign remainder = rem;

endmodule

// ===== src/assoc_cache_lru_random_tags.sv =====
// Top level of the fully associative tag and replacement controller.
// Depends on aclrt_pkg and aclrt_div.
//
// One access address is taken when start is high and busy is low. Exactly one
// result beat follows. It is shown for one cycle with done high, and the
// receiver cannot hold it off. The tags live in one synchronous memory of
// MAX_LINES entries, with one read and one write port and registered read data.
// DIV_W below is max(ADDR_BITS,16). An access first runs the bit-serial divider
// for the line number. The search then reads the tags from slot 0 on, up to a
// hit or to the end of the used entries. A move to front ripples entries 0..p-1
// down one slot, where p is the slot found or filled; there is no ripple when
// p is 0. A last state places the tag, unless a miss goes unfilled, and
// registers the result, and the result beat shows in the cycle after that. A
// random replacement skips the ripple and runs the divider a second time for
// the LFSR value modulo the line count. Configuration beats are always
// accepted and must only be sent while busy is low. Writing the seed reloads
// the generator at once.
module assoc_cache_lru_random_tags #(
  parameter int MAX_LINES = 16,
  parameter int ADDR_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [ADDR_BITS-1:0]                  access_address,
  output logic                                  busy,
  output logic                                  done,
  output logic                                  hit,
  output logic [aclrt_pkg::POS_OUT_W-1:0]       position,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [aclrt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [aclrt_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int IDX_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int POS_W = $clog2(MAX_LINES + 1);
  localparam int DIV_W = (ADDR_BITS > aclrt_pkg::SEED_W) ? ADDR_BITS : aclrt_pkg::SEED_W;

  // Configuration registers.
  logic [aclrt_pkg::BW_W-1:0]     block_words;
  logic [aclrt_pkg::LINES_W-1:0]  lines_in_use;
  logic [aclrt_pkg::POLICY_W-1:0] policy;

  // Block state besides the tag memory.
  logic [aclrt_pkg::SEED_W-1:0] lfsr;
  logic [POS_W-1:0]             valid_count;
  aclrt_pkg::state_t            state;

  // Per-access working registers.
  logic [ADDR_BITS-1:0] tag_q;
  logic [POS_W-1:0]     n_q;
  logic [POS_W-1:0]     used_q;
  logic [POS_W-1:0]     k;
  logic [POS_W-1:0]     pos_q;
  logic                 hit_q;
  logic [IDX_W-1:0]     place_idx;
  logic                 place_wr;

  // Tag memory and its ports.
  logic [ADDR_BITS-1:0] mem [MAX_LINES];
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic                 rd_vld;
  logic [IDX_W-1:0]     rd_idx_q;
  logic [ADDR_BITS-1:0] rd_data;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [ADDR_BITS-1:0] wr_data;

  // Divider hookup.
  logic                       div_start;
  logic [DIV_W-1:0]           div_dividend;
  logic [aclrt_pkg::BW_W-1:0] div_divisor;
  logic                       div_done;
  logic [DIV_W-1:0]           div_quot;
  logic [aclrt_pkg::BW_W-1:0] div_rem;

  logic [aclrt_pkg::BW_W-1:0] bw_eff;
  logic [POS_W-1:0]           n_cur;
  logic [POS_W-1:0]           used_cur;
  logic [aclrt_pkg::SEED_W-1:0] lfsr_step;
  logic                       accept;
  logic                       hit_now;
  logic                       search_end;
  logic                       room;
  logic [POS_W-1:0]           front_pos;
  logic [POS_W-1:0]           k_dec;

  assign busy      = (state != aclrt_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // A line size of zero behaves as one word per line.
  assign bw_eff = (block_words == '0) ? aclrt_pkg::BW_W'(1) : block_words;

  // Effective line count: zero counts as one, anything above the built
  // depth counts as the built depth.
  always_comb begin
    if (lines_in_use == '0) begin
      n_cur = POS_W'(1);
    end else if (32'(lines_in_use) > MAX_LINES) begin
      n_cur = POS_W'(MAX_LINES);
    end else begin
      n_cur = POS_W'(lines_in_use);
    end
  end

  assign used_cur  = (valid_count < n_cur) ? valid_count : n_cur;
  assign lfsr_step = lfsr[0] ? ((lfsr >> 1) ^ aclrt_pkg::LFSR_TAPS) : (lfsr >> 1);

  // The search streams one read per cycle; each tag is compared the cycle
  // after its read was issued. Once a compare hits, no further read is
  // issued, so nothing stale is in flight when the move to front begins.
  assign hit_now    = (state == aclrt_pkg::S_SEARCH) && rd_vld && (rd_data == tag_q);
  assign search_end = (state == aclrt_pkg::S_SEARCH) && !hit_now && (k == used_q);
  assign room       = (used_q < n_q);
  assign k_dec      = k - POS_W'(1);

  // Slot that moves to the front: the hit slot, the first free slot, or the
  // last slot when the list is full under LRU.
  always_comb begin
    if (hit_now) begin
      front_pos = POS_W'(rd_idx_q);
    end else if (room) begin
      front_pos = used_q;
    end else begin
      front_pos = n_q - POS_W'(1);
    end
  end

  // Memory port control. During the shift, entry k-1 is read while the entry
  // read in the cycle before is written one slot further down, so the read and
  // write of a cycle never touch the same entry.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = tag_q;
    case (state)
      aclrt_pkg::S_SEARCH: begin
        rd_en   = !hit_now && (k != used_q);
        rd_addr = k[IDX_W-1:0];
      end
      aclrt_pkg::S_SHIFT: begin
        rd_en   = (k != '0);
        rd_addr = k_dec[IDX_W-1:0];
        wr_en   = rd_vld;
        wr_addr = rd_idx_q + IDX_W'(1);
        wr_data = rd_data;
      end
      aclrt_pkg::S_PLACE: begin
        wr_en   = place_wr;
        wr_addr = place_idx;
        wr_data = tag_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    rd_idx_q <= rd_addr;
  end

  // The divider serves the line number at the start of an access and the
  // random slot pick after a miss on a full list under the random policy.
  assign div_start    = accept ||
                        (search_end && !room && (policy == aclrt_pkg::POL_RANDOM));
  assign div_dividend = (state == aclrt_pkg::S_IDLE) ? DIV_W'(access_address)
                                                     : DIV_W'(lfsr_step);
  assign div_divisor  = (state == aclrt_pkg::S_IDLE) ? bw_eff : aclrt_pkg::BW_W'(n_q);

  aclrt_div #(
    .DW (DIV_W),
    .VW (aclrt_pkg::BW_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // Control state, configuration and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= aclrt_pkg::S_IDLE;
      block_words  <= aclrt_pkg::BW_W'(1);
      lines_in_use <= aclrt_pkg::LINES_W'(16);
      policy       <= aclrt_pkg::POL_LRU;
      lfsr         <= aclrt_pkg::SEED_W'(1);
      valid_count  <= '0;
      rd_vld       <= 1'b0;
      done         <= 1'b0;
    end else begin
      rd_vld <= rd_en;
      done   <= 1'b0;
      case (state)
        aclrt_pkg::S_IDLE: begin
          if (accept) begin
            state <= aclrt_pkg::S_DIV;
          end
        end
        aclrt_pkg::S_DIV: begin
          if (div_done) begin
            state <= aclrt_pkg::S_SEARCH;
          end
        end
        aclrt_pkg::S_SEARCH: begin
          if (hit_now || (search_end && (room || policy == aclrt_pkg::POL_LRU))) begin
            if (search_end) begin
              if (room) begin
                valid_count <= used_q + POS_W'(1);
              end
            end
            if (front_pos == '0) begin
              state <= aclrt_pkg::S_PLACE;
            end else begin
              state <= aclrt_pkg::S_SHIFT;
            end
          end else if (search_end) begin
            if (policy == aclrt_pkg::POL_RANDOM) begin
              lfsr  <= lfsr_step;
              state <= aclrt_pkg::S_RMOD;
            end else begin
              state <= aclrt_pkg::S_PLACE;
            end
          end
        end
        aclrt_pkg::S_RMOD: begin
          if (div_done) begin
            state <= aclrt_pkg::S_PLACE;
          end
        end
        aclrt_pkg::S_SHIFT: begin
          if (k == '0 && rd_vld) begin
            state <= aclrt_pkg::S_PLACE;
          end
        end
        aclrt_pkg::S_PLACE: begin
          done  <= 1'b1;
          state <= aclrt_pkg::S_IDLE;
        end
        default: begin
          state <= aclrt_pkg::S_IDLE;
        end
      endcase

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          aclrt_pkg::CFG_BLOCK_WORDS:  block_words  <= cfg_data[aclrt_pkg::BW_W-1:0];
          aclrt_pkg::CFG_LINES_IN_USE: lines_in_use <= cfg_data[aclrt_pkg::LINES_W-1:0];
          aclrt_pkg::CFG_POLICY:       policy       <= cfg_data[aclrt_pkg::POLICY_W-1:0];
          aclrt_pkg::CFG_RANDOM_SEED: begin
            // A zero seed would lock the generator, so it loads as one.
            if (cfg_data[aclrt_pkg::SEED_W-1:0] == '0) begin
              lfsr <= aclrt_pkg::SEED_W'(1);
            end else begin
              lfsr <= cfg_data[aclrt_pkg::SEED_W-1:0];
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Per-access working registers and the result payload.
  always_ff @(posedge clk) begin
    case (state)
      aclrt_pkg::S_IDLE: begin
        if (accept) begin
          n_q    <= n_cur;
          used_q <= used_cur;
        end
      end
      aclrt_pkg::S_DIV: begin
        if (div_done) begin
          tag_q <= div_quot[ADDR_BITS-1:0];
          k     <= '0;
        end
      end
      aclrt_pkg::S_SEARCH: begin
        if (hit_now || search_end) begin
          hit_q     <= hit_now;
          pos_q     <= front_pos;
          k         <= front_pos;
          place_idx <= '0;
          place_wr  <= 1'b1;
          if (search_end && !room && policy != aclrt_pkg::POL_LRU &&
              policy != aclrt_pkg::POL_RANDOM) begin
            // No fill: report the miss without touching the list.
            pos_q    <= POS_W'(MAX_LINES);
            place_wr <= 1'b0;
          end
        end else if (rd_en) begin
          k <= k + POS_W'(1);
        end
      end
      aclrt_pkg::S_RMOD: begin
        if (div_done) begin
          place_idx <= div_rem[IDX_W-1:0];
          pos_q     <= POS_W'(div_rem);
        end
      end
      aclrt_pkg::S_SHIFT: begin
        if (k != '0) begin
          k <= k_dec;
        end
      end
      aclrt_pkg::S_PLACE: begin
        hit      <= hit_q;
        position <= aclrt_pkg::POS_OUT_W'(pos_q);
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== test/aclrt_tag_checker.sv =====
// Checker for the associative tag controller: watches the access, result and
// register channels, keeps its own tag list and hands failure counts upward.
// Depends on aclrt_pkg for widths, register indexes and policy codes.
module aclrt_tag_checker #(
  parameter int MAX_LINES = 16,
  parameter int ADDR_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [ADDR_BITS-1:0]              access_address,
  input  logic                              busy,
  input  logic                              done,
  input  logic                              hit,
  input  logic [aclrt_pkg::POS_OUT_W-1:0]   position,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [aclrt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [aclrt_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                                fail_count,
  output int                                pending,
  output int                                checked,
  output int                                hit_total,
  output int                                replace_total,
  output int                                unplaced_total
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ADDR_BITS-1:0]            addr;
    logic                            hit;
    logic [aclrt_pkg::POS_OUT_W-1:0] position;
  } lookup_t;

  localparam logic [aclrt_pkg::POS_OUT_W-1:0] NOT_PLACED = aclrt_pkg::POS_OUT_W'(MAX_LINES);

  // Predicted state: tags in most-recently-used order, fill level, generator.
  logic [ADDR_BITS-1:0]           tag_mem [MAX_LINES];
  int                             fill_level = 0;
  logic [aclrt_pkg::SEED_W-1:0]   lfsr_q = 16'd1;

  logic [aclrt_pkg::BW_W-1:0]     line_words = 9'd1;
  logic [aclrt_pkg::LINES_W-1:0]  lines_cfg  = aclrt_pkg::LINES_W'(MAX_LINES);
  logic [aclrt_pkg::POLICY_W-1:0] policy_cfg = aclrt_pkg::POL_LRU;

  lookup_t expected_q[$];
  int errors = 0, checked_n = 0, hits_n = 0, replaced_n = 0, unplaced_n = 0;

  function automatic logic [aclrt_pkg::SEED_W-1:0] lfsr_advance(
      input logic [aclrt_pkg::SEED_W-1:0] v);
    return v[0] ? ((v >> 1) ^ aclrt_pkg::LFSR_TAPS) : (v >> 1);
  endfunction

  task automatic move_to_front(input int slot, input logic [ADDR_BITS-1:0] tag);
    int k;
    for (k = slot; k > 0; k--) tag_mem[k] = tag_mem[k-1];
    tag_mem[0] = tag;
  endtask

  task automatic predict_lookup(input logic [ADDR_BITS-1:0] addr, output lookup_t res);
    int divisor, n, used, slot, k;
    logic [ADDR_BITS-1:0] tag;
    divisor = (line_words == '0) ? 1 : int'(line_words);
    tag = ADDR_BITS'(int'(addr) / divisor);
    if (lines_cfg == '0) n = 1;
    else if (int'(lines_cfg) > MAX_LINES) n = MAX_LINES;
    else n = int'(lines_cfg);
    used = (fill_level < n) ? fill_level : n;
    res.addr = addr;
    res.hit = 1'b0;
    slot = MAX_LINES;
    for (k = 0; k < used && !res.hit; k++) begin
      if (tag_mem[k] == tag) begin
        res.hit = 1'b1;
        slot = k;
      end
    end
    if (res.hit) begin
      move_to_front(slot, tag);
    end else if (used < n) begin
      slot = used;
      move_to_front(slot, tag);
      fill_level = used + 1;
    end else if (policy_cfg == aclrt_pkg::POL_LRU) begin
      slot = n - 1;
      move_to_front(slot, tag);
      replaced_n++;
    end else if (policy_cfg == aclrt_pkg::POL_RANDOM) begin
      lfsr_q = lfsr_advance(lfsr_q);
      slot = int'(lfsr_q) % n;
      tag_mem[slot] = tag;
      replaced_n++;
    end else begin
      slot = MAX_LINES;
    end
    res.position = aclrt_pkg::POS_OUT_W'(slot);
  endtask

  always @(posedge clk) begin : watch
    lookup_t want;
    if (rst) begin
      line_words = 9'd1;
      lines_cfg = aclrt_pkg::LINES_W'(MAX_LINES);
      policy_cfg = aclrt_pkg::POL_LRU;
      lfsr_q = 16'd1;
      fill_level = 0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          aclrt_pkg::CFG_BLOCK_WORDS:  line_words = cfg_data[aclrt_pkg::BW_W-1:0];
          aclrt_pkg::CFG_LINES_IN_USE: lines_cfg = cfg_data[aclrt_pkg::LINES_W-1:0];
          aclrt_pkg::CFG_POLICY:       policy_cfg = cfg_data[aclrt_pkg::POLICY_W-1:0];
          aclrt_pkg::CFG_RANDOM_SEED:
            lfsr_q = (cfg_data == '0) ? 16'd1 : cfg_data[aclrt_pkg::SEED_W-1:0];
          default: begin
          end
        endcase
      end
      // The result is matched before a new access is queued in the same cycle.
      if (done) begin
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat, expected none, actual hit %0b position %0d",
                   $time, hit, position);
        end else begin
          want = expected_q.pop_front();
          checked_n++;
          if (hit !== want.hit) begin
            errors++;
            $display("%0t: address %h hit expected %0b actual %0b",
                     $time, want.addr, want.hit, hit);
          end
          if (position !== want.position) begin
            errors++;
            $display("%0t: address %h position expected %0d actual %0d",
                     $time, want.addr, want.position, position);
          end
        end
      end
      if (start && !busy) begin
        predict_lookup(access_address, want);
        if (want.hit) hits_n++;
        if (want.position == NOT_PLACED) unplaced_n++;
        expected_q.push_back(want);
      end
    end
    pending <= expected_q.size();
    fail_count <= errors;
    checked <= checked_n;
    hit_total <= hits_n;
    replace_total <= replaced_n;
    unplaced_total <= unplaced_n;
  end

endmodule

// ===== test/assoc_cache_lru_random_tags_tb.sv =====
// Testbench top for the associative tag controller: drives access beats and
// register writes, and leaves prediction and comparison to aclrt_tag_checker.
// Depends on aclrt_pkg, aclrt_tag_checker and assoc_cache_lru_random_tags.
module assoc_cache_lru_random_tags_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LINES     = 16;
  localparam int ADDR_BITS     = 16;
  localparam int RANDOM_ITEMS  = 1750;
  localparam int MAX_GAP       = 17;
  // The slowest legal run is roughly 1900 accesses with their gaps, so this
  // leaves a wide margin.
  localparam int CYCLE_LIMIT   = 1000000;
  // Settling time after the last access; it covers a late extra beat.
  localparam int SETTLE_CYCLES = 100;

  // Policy codes the package leaves unnamed: both mean that a miss on a full
  // list is only reported.
  localparam logic [aclrt_pkg::POLICY_W-1:0] POL_NO_FILL = 2'd2;
  localparam logic [aclrt_pkg::POLICY_W-1:0] POL_SPARE   = 2'd3;

  logic                              clk;
  logic                              rst;
  logic                              start;
  logic [ADDR_BITS-1:0]              access_address;
  logic                              busy;
  logic                              done;
  logic                              hit;
  logic [aclrt_pkg::POS_OUT_W-1:0]   position;
  logic                              cfg_valid;
  logic                              cfg_ready;
  logic [aclrt_pkg::CFG_IDX_W-1:0]   cfg_index;
  logic [aclrt_pkg::CFG_DATA_W-1:0]  cfg_data;

  int fail_count, pending, checked, hit_total, replace_total, unplaced_total;
  int cycle_count = 0;
  int phase_count = 0;
  int random_sent = 0;

  // Line size as last written, used only to shape addresses into working sets.
  logic [aclrt_pkg::BW_W-1:0] cur_bw = 9'd1;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  assoc_cache_lru_random_tags #(
    .MAX_LINES(MAX_LINES),
    .ADDR_BITS(ADDR_BITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .access_address(access_address),
    .busy(busy),
    .done(done),
    .hit(hit),
    .position(position),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  aclrt_tag_checker #(
    .MAX_LINES(MAX_LINES),
    .ADDR_BITS(ADDR_BITS)
  ) tag_check (
    .clk(clk),
    .rst(rst),
    .start(start),
    .access_address(access_address),
    .busy(busy),
    .done(done),
    .hit(hit),
    .position(position),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .fail_count(fail_count),
    .pending(pending),
    .checked(checked),
    .hit_total(hit_total),
    .replace_total(replace_total),
    .unplaced_total(unplaced_total)
  );

  // One register beat. The valid is dropped after the handshake before the task returns,
  // so back-to-back writes never touch cfg_valid twice in a step.
  task automatic write_reg(input logic [aclrt_pkg::CFG_IDX_W-1:0] idx,
                           input logic [aclrt_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == aclrt_pkg::CFG_BLOCK_WORDS) cur_bw = value[aclrt_pkg::BW_W-1:0];
  endtask

  // One access beat. With no gap, start simply stays high and only the
  // address changes, so start never sees a low and a high in the same step.
  task automatic send_access(input logic [ADDR_BITS-1:0] addr, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    access_address <= addr;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Lowers start and holds off until every predicted result has come back and
  // the block reports idle. The first edge lets the checker count the last beat.
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
  endtask

  // Watchdog: a hang or a missing result ends the run here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    int                               i, phase_len, ws_size, divisor, base_tag, gap;
    bit                               steady;
    logic [ADDR_BITS-1:0]             addr;
    logic [aclrt_pkg::CFG_DATA_W-1:0] word;
    logic [aclrt_pkg::BW_W-1:0]       bw_val;
    logic [aclrt_pkg::LINES_W-1:0]    lines_val;

    rst <= 1'b1;
    start <= 1'b0;
    access_address <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= aclrt_pkg::CFG_BLOCK_WORDS;
    cfg_data <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);

    // Directed part. A four-entry list with a zero seed, which must load as one.
    write_reg(aclrt_pkg::CFG_LINES_IN_USE, 16'd4);
    write_reg(aclrt_pkg::CFG_RANDOM_SEED, 16'd0);
    // Lowest and highest addresses, a hit, a fill to full, then two LRU evictions.
    send_access(16'h0000, 0);
    send_access(16'hFFFF, 0);
    send_access(16'h0000, 0);
    send_access(16'h0001, 0);
    send_access(16'h0002, 0);
    send_access(16'h0003, 0);
    send_access(16'hFFFF, 0);

    // Random replacement on a full list overwrites in place.
    wait_idle();
    write_reg(aclrt_pkg::CFG_POLICY, {14'd0, aclrt_pkg::POL_RANDOM});
    send_access(16'h1234, 0);
    send_access(16'h8000, 0);
    send_access(16'h4321, 0);

    // The spare policy code and the explicit no-fill code only report the miss.
    wait_idle();
    write_reg(aclrt_pkg::CFG_POLICY, {14'd0, POL_SPARE});
    send_access(16'h5555, 0);
    send_access(16'h8000, 0);
    wait_idle();
    write_reg(aclrt_pkg::CFG_POLICY, {14'd0, POL_NO_FILL});
    send_access(16'hAAAA, 0);

    // Zero lines counts as one and drops below the fill level: only the front
    // entry is searched and the list counts as full.
    wait_idle();
    write_reg(aclrt_pkg::CFG_LINES_IN_USE, 16'd0);
    send_access(16'h8000, 0);
    send_access(16'hAAAA, 0);

    // A line count above the built depth is clipped; zero line size means one.
    wait_idle();
    write_reg(aclrt_pkg::CFG_LINES_IN_USE, 16'd31);
    write_reg(aclrt_pkg::CFG_POLICY, {14'd0, aclrt_pkg::POL_LRU});
    write_reg(aclrt_pkg::CFG_BLOCK_WORDS, 16'd0);
    send_access(16'h7FFF, 0);
    send_access(16'h7FFF, 0);

    // Largest line sizes, with addresses on both sides of a line boundary.
    wait_idle();
    write_reg(aclrt_pkg::CFG_BLOCK_WORDS, 16'd511);
    send_access(16'hFFFF, 0);
    send_access(16'hFE01, 0);
    send_access(16'h01FF, 0);
    wait_idle();
    write_reg(aclrt_pkg::CFG_BLOCK_WORDS, 16'd256);
    send_access(16'h00FF, 0);
    send_access(16'h0100, 0);

    // Random part: phases of new settings, each over a working set of line
    // numbers a little larger or smaller than the list, so hits, fills and
    // every kind of replacement keep happening. Upper bits of the register
    // data beyond each field are random and must be ignored.
    while (random_sent < RANDOM_ITEMS) begin
      wait_idle();
      phase_count++;
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 5))
          0:       bw_val = 9'd0;
          1:       bw_val = 9'd1;
          2:       bw_val = 9'd256;
          3:       bw_val = 9'd511;
          4:       bw_val = aclrt_pkg::BW_W'($urandom_range(2, 8));
          default: bw_val = aclrt_pkg::BW_W'($urandom_range(9, 255));
        endcase
        word = aclrt_pkg::CFG_DATA_W'($urandom);
        word[aclrt_pkg::BW_W-1:0] = bw_val;
        write_reg(aclrt_pkg::CFG_BLOCK_WORDS, word);
      end
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 5))
          0:       lines_val = 5'd0;
          1:       lines_val = 5'd1;
          2:       lines_val = 5'd16;
          3:       lines_val = 5'd31;
          4:       lines_val = aclrt_pkg::LINES_W'($urandom_range(2, 15));
          default: lines_val = aclrt_pkg::LINES_W'($urandom_range(17, 30));
        endcase
        word = aclrt_pkg::CFG_DATA_W'($urandom);
        word[aclrt_pkg::LINES_W-1:0] = lines_val;
        write_reg(aclrt_pkg::CFG_LINES_IN_USE, word);
      end
      if ($urandom_range(0, 1) == 0) begin
        word = aclrt_pkg::CFG_DATA_W'($urandom);
        write_reg(aclrt_pkg::CFG_POLICY, word);
      end
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 3))
          0:       word = 16'h0000;
          1:       word = 16'h0001;
          2:       word = 16'hFFFF;
          default: word = aclrt_pkg::CFG_DATA_W'($urandom);
        endcase
        write_reg(aclrt_pkg::CFG_RANDOM_SEED, word);
      end

      divisor = (cur_bw == '0) ? 1 : int'(cur_bw);
      phase_len = $urandom_range(40, 120);
      ws_size = $urandom_range(1, 24);
      base_tag = $urandom_range(0, (65536 / divisor) - 1);
      // About a quarter of the phases send every access with a gap of zero.
      steady = ($urandom_range(0, 3) == 0);
      for (i = 0; i < phase_len; i++) begin
        if ($urandom_range(0, 4) == 0) begin
          addr = ADDR_BITS'($urandom);
        end else begin
          addr = ADDR_BITS'((base_tag + int'($urandom_range(0, ws_size - 1))) * divisor
                            + int'($urandom_range(0, divisor - 1)));
        end
        gap = steady ? 0 : $urandom_range(0, MAX_GAP);
        // Now and then the sender holds off until every result is back and the block is idle.
        if ($urandom_range(0, 49) == 0) wait_idle();
        send_access(addr, gap);
        random_sent++;
      end
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d setting phases and %0d checked accesses:", phase_count, checked);
    $display("  %0d hits, %0d evictions by LRU or random slot, %0d misses left unplaced.",
             hit_total, replace_total, unplaced_total);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
